// ===== rtl/slpq_pkg.sv =====
// Types and codes shared by the sorted-list priority queue modules.
package slpq_pkg;

  localparam int KEY_W   = 8;
  localparam int TILES_W = 36;
  localparam int DEPTH_W = 4;
  localparam int BLANK_W = 4;
  localparam int MOVE_W  = 2;
  localparam int HIST_W  = 24;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int DATA_W  = 80;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [HIST_W-1:0]  history;
    logic [MOVE_W-1:0]  last_move;
    logic [BLANK_W-1:0] blank;
    logic [DEPTH_W-1:0] depth;
    logic [TILES_W-1:0] tiles;
    logic [KEY_W-1:0]   key;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    logic   clr;
    entry_t ent;
  } cell_ctl_t;

endpackage

// ===== rtl/sorted_list_priority_queue.sv =====
// Top level of the sorted-list priority queue built from a chain of cells.
//
// Usage:
//   Input words carry an operation in in_tuser (insert, pop head, clear) and
//   the entry in in_tdata. Every accepted word gives exactly one result word:
//   out_tuser holds the status and the now-empty flag, out_tdata the popped
//   entry (all zero for anything but a successful pop).
//   Entries are kept sorted in a row of ENTRIES cells, lowest key in cell 0.
//   An insert shifts every cell whose key is at or above the new key one
//   place along, so among equal keys the newest is served first; a pop
//   shifts the whole row one place towards cell 0.
//   The result is registered in the cycle after acceptance. One word is
//   taken per cycle while out_tready is high, the whole row updating at once.
//   An insert into a full row is dropped with status 1; a pop on an empty
//   row returns status 2. Reset and clear empty every cell at once.
//   While a result waits on a stalled receiver, in_tready stays high only if
//   out_tready is high in the same cycle; no word is lost or repeated.
module sorted_list_priority_queue #(
  parameter int ENTRIES   = 255,
  parameter int MAX_MOVES = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // key, tiles, depth, blank, last_move, move_history, zero pad
  input  logic [slpq_pkg::DATA_W-1:0] in_tdata,
  // kind
  input  logic [slpq_pkg::KIND_W-1:0] in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_key, out_tiles, out_depth, out_blank, out_last_move, out_history, zero pad
  output logic [slpq_pkg::DATA_W-1:0] out_tdata,
  // status, now_empty
  output logic [slpq_pkg::STAT_W:0]   out_tuser
);
  import slpq_pkg::*;

  entry_t             cell_q [ENTRIES];
  logic [ENTRIES-1:0] cell_v;
  logic [ENTRIES-1:0] cell_push;
  cell_ctl_t          ctl;
  entry_t             in_ent;
  logic [DEPTH_W-1:0] moves;
  logic [HIST_W-1:0]  hist_mask;
  logic               in_acc;
  logic               full;

  logic               out_valid_r;
  entry_t             out_ent_r, out_ent_nxt;
  logic [STAT_W-1:0]  out_stat_r, out_stat_nxt;
  logic               out_empty_r, out_empty_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign full      = cell_v[ENTRIES-1];

  // only the first min(depth, MAX_MOVES) moves are kept
  assign moves = (in_tdata[47:44] > DEPTH_W'(MAX_MOVES)) ? DEPTH_W'(MAX_MOVES)
                                                          : in_tdata[47:44];
  always_comb begin
    for (int b = 0; b < HIST_W; b++) begin
      hist_mask[b] = (5'(b) < {moves, 1'b0});
    end
  end

  always_comb begin
    in_ent           = '0;
    in_ent.key       = in_tdata[7:0];
    in_ent.tiles     = in_tdata[43:8];
    in_ent.depth     = in_tdata[47:44];
    in_ent.blank     = in_tdata[51:48];
    in_ent.last_move = in_tdata[53:52];
    in_ent.history   = in_tdata[77:54] & hist_mask;
  end

  always_comb begin
    ctl.ent = in_ent;
    ctl.ins = in_acc && (in_tuser == KIND_INSERT) && !full;
    ctl.pop = in_acc && (in_tuser == KIND_POP) && cell_v[0];
    ctl.clr = in_acc && (in_tuser == KIND_CLEAR);
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_v, left_p, right_v;
    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_v = 1'b0;
      assign left_p = 1'b0;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_v = cell_v[i-1];
      assign left_p = cell_push[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign right_e = '0;
      assign right_v = 1'b0;
    end else begin : g_inner
      assign right_e = cell_q[i+1];
      assign right_v = cell_v[i+1];
    end
    slpq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_entry  (left_e),
      .left_valid  (left_v),
      .left_push   (left_p),
      .right_entry (right_e),
      .right_valid (right_v),
      .entry       (cell_q[i]),
      .valid       (cell_v[i]),
      .push        (cell_push[i])
    );
  end

  always_comb begin
    out_ent_nxt   = '0;
    out_stat_nxt  = STAT_DONE;
    out_empty_nxt = !cell_v[0];
    case (in_tuser)
      KIND_INSERT: begin
        if (full) begin
          out_stat_nxt = STAT_FULL;
        end else begin
          out_empty_nxt = 1'b0;
        end
      end
      KIND_POP: begin
        if (!cell_v[0]) begin
          out_stat_nxt = STAT_EMPTY;
        end else begin
          out_ent_nxt   = cell_q[0];
          out_empty_nxt = !cell_v[1];
        end
      end
      KIND_CLEAR: begin
        out_empty_nxt = 1'b1;
      end
      default: begin
        out_empty_nxt = !cell_v[0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_ent_r   <= out_ent_nxt;
      out_stat_r  <= out_stat_nxt;
      out_empty_r <= out_empty_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_empty_r, out_stat_r};
  assign out_tdata  = {2'b00, out_ent_r.history, out_ent_r.last_move, out_ent_r.blank,
                       out_ent_r.depth, out_ent_r.tiles, out_ent_r.key};

`ifndef NO_ASSERTIONS
  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_v[ENTRIES-1:1] & ~cell_v[ENTRIES-2:0]) == '0)
    else $error("occupied cells not contiguous from cell 0");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    cell_v[1] |-> (cell_q[0].key <= cell_q[1].key))
    else $error("head cells out of key order");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |=> (cell_v == '0))
    else $error("clear left occupied cells");

  a_insert_fills: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> (cell_v[0] && ($countones(cell_v) == $countones($past(cell_v)) + 1)))
    else $error("insert did not add exactly one entry");
`endif

endmodule

// ===== rtl/slpq_cell.sv =====
// One cell of the sorted chain: holds one entry and shifts on insert or pop.
module slpq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  slpq_pkg::cell_ctl_t ctl,
  input  slpq_pkg::entry_t   left_entry,
  input  logic               left_valid,
  input  logic               left_push,
  input  slpq_pkg::entry_t   right_entry,
  input  logic               right_valid,
  output slpq_pkg::entry_t   entry,
  output logic               valid,
  output logic               push
);
  import slpq_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;

  // cell moves right when empty or its key is not below the new key
  assign push = !valid_r || (entry_r.key >= ctl.ent.key);

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.pop) begin
      entry_nxt = right_entry;
      valid_nxt = right_valid;
    end else if (ctl.ins && push) begin
      if (left_push) begin
        entry_nxt = left_entry;
        valid_nxt = left_valid;
      end else begin
        entry_nxt = ctl.ent;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule
